// File: sv/bos_pkg.sv
// Shared definitions for the bounded operand stack: transfer payload types,
// action and status codes, and default sizes. No dependencies.
package bos_pkg;

    localparam int DEF_STACK_DEPTH = 1024;
    localparam int DEF_HANDLE_BITS = 32;

    localparam logic [2:0] ACT_PUSH  = 3'd0;
    localparam logic [2:0] ACT_POP   = 3'd1;
    localparam logic [2:0] ACT_DUP   = 3'd2;
    localparam logic [2:0] ACT_SWAP  = 3'd3;
    localparam logic [2:0] ACT_SLICE = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_SLICE = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] push_handle;
        logic [10:0] slice_start;
        logic [10:0] slice_count;
    } req_t;

    typedef struct packed {
        logic [31:0] read_handle;
        logic [1:0]  status;
        logic [10:0] depth;
        logic [10:0] high_water;
    } rsp_t;

endpackage

// File: sv/bos_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
module bos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: sv/bounded_operand_stack_top.sv
// Top level of the bounded operand stack: request decode, the access
// sequencer around the handle RAM, and the response register.
// Depends on bos_pkg and bos_ram.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | req_valid/req_stall  | req_t: action, handle, slice
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_t: handle, status, depths
//
// Steps per request: push, an unused action or any error go straight to the
// response; pop and dup add a RAM read wait; swap reads, then writes top and
// next; slice adds a move step per entry moved down, as the handle RAM has a
// single read and single write port, its read data arriving in the cycle after the address.
// Reset clears the depth, the high-water mark, the sequencer and the response
// valid; the handle RAM is not cleared, as an entry is only read once written.
// req_stall is high whenever a request is in progress. A stalled response
// holds the sequencer in its final step, but a finished response waiting in
// the output register does not stop the next request from being accepted.
module bounded_operand_stack_top #(
    parameter int STACK_DEPTH = bos_pkg::DEF_STACK_DEPTH,
    parameter int HANDLE_BITS = bos_pkg::DEF_HANDLE_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bos_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bos_pkg::rsp_t rsp
);

    import bos_pkg::*;

    // Address width of the RAM, width of the depth counter (it must hold the
    // full depth itself) and the width used for slice range arithmetic.
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int CW = (DW > 12) ? DW + 1 : 13;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_WAIT,
        S_DUP_WAIT,
        S_SWAP_RD,
        S_SWAP_WR_TOP,
        S_SWAP_WR_NEXT,
        S_SLICE_RUN,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [DW-1:0]          depth_reg;
    logic [DW-1:0]          peak_reg;
    logic [1:0]             status_reg;
    logic [31:0]            read_reg;
    logic [HANDLE_BITS-1:0] tmp_reg;
    logic [AW-1:0]          src_reg;
    logic [AW-1:0]          dst_reg;
    logic [DW-1:0]          remain_reg;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;

    logic                   accept;
    logic                   out_free;
    logic [CW-1:0]          slice_sum;
    logic [CW-1:0]          slice_keep;
    logic                   full;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [HANDLE_BITS-1:0] wr_data;
    logic [AW-1:0]          rd_addr;
    logic [HANDLE_BITS-1:0] rd_data;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign full       = (depth_reg == DW'(STACK_DEPTH));
    assign slice_sum  = CW'(req.slice_start) + CW'(req.slice_count);
    assign slice_keep = CW'(depth_reg) - slice_sum;

    // RAM port steering. The read address in the idle state is presented in
    // the same cycle as the request, so the data is ready in the next cycle.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = AW'(depth_reg);
        wr_data = HANDLE_BITS'(req.push_handle);
        rd_addr = AW'(depth_reg - DW'(1));
        unique case (state_reg)
            S_IDLE:
            begin
                wr_en = accept && (req.action == ACT_PUSH) && !full;
                if (req.action == ACT_SLICE)
                begin
                    rd_addr = AW'(slice_sum);
                end
            end
            S_DUP_WAIT:
            begin
                wr_en   = 1'b1;
                wr_data = rd_data;
            end
            S_SWAP_RD:
            begin
                rd_addr = AW'(depth_reg - DW'(2));
            end
            S_SWAP_WR_TOP:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(depth_reg - DW'(1));
                wr_data = rd_data;
            end
            S_SWAP_WR_NEXT:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(depth_reg - DW'(2));
                wr_data = tmp_reg;
            end
            S_SLICE_RUN:
            begin
                wr_en   = 1'b1;
                wr_addr = dst_reg;
                wr_data = rd_data;
                rd_addr = src_reg;
            end
            default:
            begin
            end
        endcase
    end

    bos_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            peak_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // The response valid is raised when the final step loads the output
            // register and dropped once the waiting response has been taken.
            if (state_reg == S_EMIT && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg <= ST_OK;
                        read_reg   <= '0;
                        state_reg  <= S_EMIT;
                        unique case (req.action)
                            ACT_PUSH:
                            begin
                                if (full)
                                begin
                                    status_reg <= ST_OVER;
                                end
                                else
                                begin
                                    depth_reg <= depth_reg + DW'(1);
                                    if (depth_reg + DW'(1) > peak_reg)
                                    begin
                                        peak_reg <= depth_reg + DW'(1);
                                    end
                                end
                            end
                            ACT_POP:
                            begin
                                if (depth_reg == '0)
                                begin
                                    status_reg <= ST_UNDER;
                                end
                                else
                                begin
                                    depth_reg <= depth_reg - DW'(1);
                                    state_reg <= S_POP_WAIT;
                                end
                            end
                            ACT_DUP:
                            begin
                                if (depth_reg == '0)
                                begin
                                    status_reg <= ST_UNDER;
                                end
                                else if (full)
                                begin
                                    status_reg <= ST_OVER;
                                end
                                else
                                begin
                                    state_reg <= S_DUP_WAIT;
                                end
                            end
                            ACT_SWAP:
                            begin
                                if (depth_reg < DW'(2))
                                begin
                                    status_reg <= ST_UNDER;
                                end
                                else
                                begin
                                    state_reg <= S_SWAP_RD;
                                end
                            end
                            ACT_SLICE:
                            begin
                                if (slice_sum > CW'(depth_reg))
                                begin
                                    status_reg <= ST_SLICE;
                                end
                                else
                                begin
                                    depth_reg <= DW'(CW'(depth_reg) - CW'(req.slice_count));
                                    dst_reg    <= AW'(req.slice_start);
                                    src_reg    <= AW'(slice_sum + CW'(1));
                                    remain_reg <= DW'(slice_keep);
                                    // Nothing to move when the gap is empty or
                                    // the removed run reaches the top.
                                    if ((req.slice_count != '0) && (slice_keep != '0))
                                    begin
                                        state_reg <= S_SLICE_RUN;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_POP_WAIT:
                begin
                    read_reg  <= 32'(rd_data);
                    state_reg <= S_EMIT;
                end
                S_DUP_WAIT:
                begin
                    depth_reg <= depth_reg + DW'(1);
                    if (depth_reg + DW'(1) > peak_reg)
                    begin
                        peak_reg <= depth_reg + DW'(1);
                    end
                    state_reg <= S_EMIT;
                end
                S_SWAP_RD:
                begin
                    tmp_reg   <= rd_data;
                    state_reg <= S_SWAP_WR_TOP;
                end
                S_SWAP_WR_TOP:
                begin
                    state_reg <= S_SWAP_WR_NEXT;
                end
                S_SWAP_WR_NEXT:
                begin
                    state_reg <= S_EMIT;
                end
                S_SLICE_RUN:
                begin
                    src_reg    <= src_reg + AW'(1);
                    dst_reg    <= dst_reg + AW'(1);
                    remain_reg <= remain_reg - DW'(1);
                    if (remain_reg == DW'(1))
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        rsp_reg.read_handle <= read_reg;
                        rsp_reg.status      <= status_reg;
                        rsp_reg.depth       <= 11'(depth_reg);
                        rsp_reg.high_water  <= 11'(peak_reg);
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The depth never passes the capacity and the high-water mark never
    // falls below the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (depth_reg <= DW'(STACK_DEPTH)) && (peak_reg >= depth_reg))
        else $error("stack depth or high-water mark out of range");

    // The high-water mark is never lowered.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (peak_reg >= $past(peak_reg)))
        else $error("high-water mark decreased");

    // In the idle state only a push writes the RAM.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && wr_en) |-> (accept && req.action == ACT_PUSH))
        else $error("unexpected RAM write while idle");

    // A slice move always has at least one entry left to copy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SLICE_RUN) |-> (remain_reg != '0))
        else $error("slice move running with nothing left");

    // A response is loaded only from the final step, and then the block is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> (rsp_valid && state_reg == S_IDLE))
        else $error("response not issued from final step");

endmodule

// File: tb/bounded_operand_stack_top_tb.sv
// Self-checking testbench for bounded_operand_stack_top: a shadow stack predicts
// every response, and randomised transfers run with idling and a long receiver hold.
// Depends on bos_pkg and the RTL of bounded_operand_stack_top with its bos_ram.
`timescale 1ns / 1ps

module bounded_operand_stack_top_tb;

    import bos_pkg::*;

    // Sizes follow the block's defaults, as the instance below is not overridden.
    localparam int STACK_SIZE   = DEF_STACK_DEPTH;
    localparam int RANDOM_ITEMS = 500;
    // The longest correct silence is a slice that moves almost the whole stack
    // or the deliberate receiver hold below; both are far inside this limit.
    localparam int QUIET_LIMIT  = 6000;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int SENDER       = 0;
    localparam int RECEIVER     = 1;

    // The shadow stack holds its own copy of the handle store, the depth and the
    // high-water mark, and queues the response that each accepted request must give.
    class stack_shadow;
        logic [31:0] slots [STACK_SIZE];
        int          level;
        int          peak;
        int          faults;
        rsp_t        awaited [$];

        task report(string msg);
            if (faults < 100)
                $display("%s", msg);
            faults++;
        endtask

        function void note_request(req_t r);
            rsp_t want;
            int   first;
            int   span;
            int   i;
            want        = '0;
            want.status = ST_OK;
            first       = int'(r.slice_start);
            span        = int'(r.slice_count);
            case (r.action)
                ACT_PUSH:
                    if (level >= STACK_SIZE)
                        want.status = ST_OVER;
                    else
                    begin
                        slots[level] = r.push_handle;
                        level++;
                    end
                ACT_POP:
                    if (level < 1)
                        want.status = ST_UNDER;
                    else
                    begin
                        level--;
                        want.read_handle = slots[level];
                    end
                ACT_DUP:
                    if (level < 1)
                        want.status = ST_UNDER;
                    else if (level >= STACK_SIZE)
                        want.status = ST_OVER;
                    else
                    begin
                        slots[level] = slots[level - 1];
                        level++;
                    end
                ACT_SWAP:
                    if (level < 2)
                        want.status = ST_UNDER;
                    else
                    begin
                        {slots[level - 1], slots[level - 2]} =
                            {slots[level - 2], slots[level - 1]};
                    end
                ACT_SLICE:
                    if (first + span > level)
                        want.status = ST_SLICE;
                    else
                    begin
                        for (i = first; i + span < level; i++)
                            slots[i] = slots[i + span];
                        level -= span;
                    end
                default:
                    ;
            endcase
            // Only push and dup can raise the depth, so this tracks the mark exactly.
            if (level > peak)
                peak = level;
            want.depth      = 11'(level);
            want.high_water = 11'(peak);
            awaited.push_back(want);
        endfunction

        task check_response(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("%0t: response with no request outstanding (status %0d)",
                                 $time, got.status));
                return;
            end
            want = awaited.pop_front();
            if (got.read_handle !== want.read_handle)
                report($sformatf("%0t: read_handle %h, predicted %h",
                                 $time, got.read_handle, want.read_handle));
            if (got.status !== want.status)
                report($sformatf("%0t: status %0d, predicted %0d",
                                 $time, got.status, want.status));
            if (got.depth !== want.depth)
                report($sformatf("%0t: depth %0d, predicted %0d",
                                 $time, got.depth, want.depth));
            if (got.high_water !== want.high_water)
                report($sformatf("%0t: high_water %0d, predicted %0d",
                                 $time, got.high_water, want.high_water));
        endtask
    endclass

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_stall;
    rsp_t  rsp;

    stack_shadow shadow = new();

    // Idling state per side: a run of items is either calm (no gaps at all) or
    // busy (a random idle gap drawn for each item).
    int stretch_left [2];
    bit calm_run     [2];

    bounded_operand_stack_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_cycles(int side);
        if (stretch_left[side] == 0)
        begin
            calm_run[side]     = ($urandom_range(0, 3) == 0);
            stretch_left[side] = $urandom_range(10, 40);
        end
        stretch_left[side]--;
        return calm_run[side] ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic req_t make_req(logic [2:0] act, logic [31:0] handle,
                                      int first, int span);
        req_t r;
        r.action      = act;
        r.push_handle = handle;
        r.slice_start = 11'(first);
        r.slice_count = 11'(span);
        return r;
    endfunction

    // Random request shaped by the current depth: the mix leans towards growth
    // below about 48 entries and towards shrinking above it, so the stack keeps
    // moving. Most slices are in range; one in five carries raw field values.
    function automatic req_t random_request(int d);
        req_t r;
        int   pick;
        int   grow;
        int   span;
        r.action      = ACT_POP;
        r.push_handle = $urandom();
        r.slice_start = 11'($urandom_range(0, 2047));
        r.slice_count = 11'($urandom_range(0, 2047));
        grow          = (d > 48) ? 20 : 40;
        pick          = $urandom_range(0, 99);
        if (pick < 3)
            r.action = 3'($urandom_range(5, 7));
        else if (pick < 3 + grow)
            r.action = ACT_PUSH;
        else if (pick < 13 + grow)
            r.action = ACT_DUP;
        else if (pick < 25 + grow)
            r.action = ACT_SWAP;
        else if (pick < 43 + grow)
        begin
            r.action = ACT_SLICE;
            if ($urandom_range(0, 4) != 0)
            begin
                r.slice_start = 11'($urandom_range(0, d));
                span          = d - int'(r.slice_start);
                if ($urandom_range(0, 3) != 0 && span > 4)
                    span = 4;
                r.slice_count = 11'($urandom_range(0, span));
            end
        end
        return r;
    endfunction

    // Offers one request, holds it until the transfer happens, and then records
    // it in the shadow stack. Noting here rather than in a monitor means the next
    // request is always generated from the updated depth.
    task automatic send_request(req_t r);
        int gap;
        gap = idle_cycles(SENDER);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        shadow.note_request(r);
    endtask

    // Grows the stack to its full size, exercises the full-stack cases, and then
    // drains it with slices, one of which moves nearly every entry down.
    task automatic fill_and_drain();
        int pick;
        while (shadow.level < STACK_SIZE)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                send_request(make_req(ACT_PUSH, $urandom(), 0, 0));
            else if (pick < 9)
                send_request(make_req(ACT_DUP, $urandom(), 0, 0));
            else
                send_request(make_req(ACT_SWAP, $urandom(), 0, 0));
        end
        send_request(make_req(ACT_PUSH, $urandom(), 0, 0));
        send_request(make_req(ACT_DUP, 32'h0, 0, 0));
        send_request(make_req(ACT_SWAP, 32'h0, 0, 0));
        send_request(make_req(ACT_POP, 32'h0, 0, 0));
        send_request(make_req(ACT_DUP, 32'h0, 0, 0));
        send_request(make_req(ACT_SLICE, 32'h0, STACK_SIZE, 0));
        send_request(make_req(ACT_SLICE, 32'h0, 0, STACK_SIZE + 1));
        send_request(make_req(ACT_SLICE, 32'h0, STACK_SIZE - 24, 24));
        send_request(make_req(ACT_SLICE, 32'h0, 0, 8));
        send_request(make_req(ACT_SLICE, 32'h0, 0, shadow.level));
    endtask

    // Responses are checked at the edge where the transfer happens; both signals
    // still hold their values from before the edge, so the sample is race free.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            shadow.check_response(rsp);
    end

    // Receiver: draws a stall for every response, and once, part-way through,
    // holds off for a long stretch so that the block backs up and stalls requests.
    initial
    begin : receiver
        int hold;
        int taken;
        taken     = 0;
        rsp_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = idle_cycles(RECEIVER);
            if (taken == HOLD_AT)
                hold = LONG_HOLD;
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            taken++;
        end
    end

    // Ends the run if neither channel completes a transfer for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("** bounded_operand_stack_top: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int   counted;
        req_t r;
        rst_n     = 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: every error on an empty or nearly empty stack, the
        // extreme handles, a slice that closes a gap, an empty slice, a slice with
        // all-ones fields, the unused action codes, and popping back to empty.
        send_request(make_req(ACT_POP, 32'h0, 0, 0));
        send_request(make_req(ACT_DUP, 32'h0, 0, 0));
        send_request(make_req(ACT_SWAP, 32'h0, 0, 0));
        send_request(make_req(ACT_SLICE, 32'h0, 0, 0));
        send_request(make_req(ACT_SLICE, 32'h0, 0, 1));
        send_request(make_req(ACT_PUSH, 32'hFFFF_FFFF, 0, 0));
        send_request(make_req(ACT_SWAP, 32'h0, 0, 0));
        send_request(make_req(ACT_PUSH, 32'h0, 0, 0));
        send_request(make_req(ACT_SWAP, 32'h0, 0, 0));
        send_request(make_req(ACT_DUP, 32'h0, 0, 0));
        send_request(make_req(ACT_PUSH, 32'hA5A5_5A5A, 0, 0));
        send_request(make_req(ACT_SLICE, 32'h0, 1, 2));
        send_request(make_req(ACT_SLICE, 32'h0, 2, 0));
        send_request(make_req(ACT_SLICE, 32'hFFFF_FFFF, 2047, 2047));
        send_request(make_req(3'd5, 32'h1234_5678, 0, 0));
        send_request(make_req(3'd6, 32'h0, 0, 0));
        send_request(make_req(3'd7, 32'hFFFF_FFFF, 2047, 2047));
        send_request(make_req(ACT_POP, 32'h0, 0, 0));
        send_request(make_req(ACT_POP, 32'h0, 0, 0));
        send_request(make_req(ACT_POP, 32'h0, 0, 0));

        // Random traffic, with a full-stack episode in the middle. Unused action
        // codes are ignored by the block and so do not count.
        counted = 0;
        while (counted < RANDOM_ITEMS / 2)
        begin
            r = random_request(shadow.level);
            send_request(r);
            if (r.action <= ACT_SLICE)
                counted++;
        end
        fill_and_drain();
        while (counted < RANDOM_ITEMS)
        begin
            r = random_request(shadow.level);
            send_request(r);
            if (r.action <= ACT_SLICE)
                counted++;
        end
        req_valid <= 1'b0;

        // Every request gives exactly one response; wait for them all, then run on
        // for DRAIN_CYCLES so that any stray extra response is caught.
        while (shadow.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (shadow.faults == 0 && shadow.awaited.size() == 0)
            $display("** bounded_operand_stack_top: PASSED **");
        else
            $display("** bounded_operand_stack_top: FAILED **");
        $finish;
    end

endmodule
